// File: sv/pnc_pkg.sv
package pnc_pkg;

	localparam int PALETTE_DEPTH = 16;
	localparam int IDX_W = $clog2(PALETTE_DEPTH);
	localparam int OUT_IDX_W = 4;
	localparam int CHAN_W = 8;
	localparam int SQ_W = 2 * CHAN_W;
	localparam int DIST_W = 18;
	localparam int COUNT_W = 5;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;
	localparam logic [DIST_W-1:0] DIST_MAX = 18'd195075;

	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;
	localparam int REG_IDX_W = ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_PALETTE_COUNT = 1'd0;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef struct packed {
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
	} color_t;

	typedef struct packed {
		op_t                  op;
		logic [OUT_IDX_W-1:0] entry_index;
		color_t               color;
	} item_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] index;
		color_t               color;
		logic [DIST_W-1:0]    distance;
	} best_t;

	function automatic logic [SQ_W-1:0] sq_diff(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
		logic [CHAN_W-1:0] d;
		d = (a >= b) ? (a - b) : (b - a);
		return SQ_W'(d) * SQ_W'(d);
	endfunction

	function automatic logic [OUT_IDX_W-1:0] low_index(logic [IDX_W-1:0] i);
		logic [31:0] w;
		w = 32'(i);
		return w[OUT_IDX_W-1:0];
	endfunction

endpackage

// File: sv/pnc_req_if.sv
interface pnc_req_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [3:0] entry_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, op, entry_index, red, green, blue, input ready);
	modport sink (input valid, op, entry_index, red, green, blue, output ready);
endinterface

// File: sv/pnc_rsp_if.sv
interface pnc_rsp_if;
	logic        valid;
	logic        ready;
	logic [3:0]  closest_index;
	logic [7:0]  closest_red;
	logic [7:0]  closest_green;
	logic [7:0]  closest_blue;
	logic [17:0] distance_squared;

	modport source (output valid, closest_index, closest_red, closest_green, closest_blue,
		distance_squared, input ready);
	modport sink (input valid, closest_index, closest_red, closest_green, closest_blue,
		distance_squared, output ready);
endinterface

// File: sv/pnc_cfg.sv
module pnc_cfg import pnc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	output logic [COUNT_W-1:0] palette_count
);

	logic [COUNT_W-1:0] count_q;
	logic               hit;

	assign hit = (paddr[ADDR_W-1:2] == REG_PALETTE_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (psel && penable && pwrite && hit) begin
			count_q <= pwdata[COUNT_W-1:0];
		end
	end

	assign prdata = hit ? DATA_W'(count_q) : '0;
	assign pready = 1'b1;
	assign palette_count = count_q;

endmodule

// File: sv/pnc_cell.sv
module pnc_cell import pnc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [IDX_W-1:0] cell_index,
	input  logic             active,
	input  logic             in_valid,
	input  item_t            in_item,
	input  best_t            in_best,
	output logic             out_valid,
	output item_t            out_item,
	output best_t            out_best
);

	color_t            entry_q;
	logic              valid_s1;
	item_t             item_s1;
	best_t             best_s1;
	color_t            entry_s1;
	logic [SQ_W-1:0]   sq_r_s1;
	logic [SQ_W-1:0]   sq_g_s1;
	logic [SQ_W-1:0]   sq_b_s1;
	logic [DIST_W-1:0] dist_sum;
	logic              take;
	logic              valid_s2;
	item_t             item_s2;
	best_t             best_s2;

	// store the entry when a load for this slot passes
	always_ff @(posedge clk) begin
		if (en && in_valid && in_item.op == OP_LOAD
			&& 32'(in_item.entry_index) == 32'(cell_index)) begin
			entry_q <= in_item.color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1  <= in_item;
			best_s1  <= in_best;
			entry_s1 <= entry_q;
			sq_r_s1  <= sq_diff(entry_q.r, in_item.color.r);
			sq_g_s1  <= sq_diff(entry_q.g, in_item.color.g);
			sq_b_s1  <= sq_diff(entry_q.b, in_item.color.b);
		end
	end

	assign dist_sum = DIST_W'(sq_r_s1) + DIST_W'(sq_g_s1) + DIST_W'(sq_b_s1);
	assign take = active && (item_s1.op == OP_QUERY)
		&& ((cell_index == '0) || (dist_sum < best_s1.distance));

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2 <= item_s1;
			if (take) begin
				best_s2.index    <= low_index(cell_index);
				best_s2.color    <= entry_s1;
				best_s2.distance <= dist_sum;
			end else begin
				best_s2 <= best_s1;
			end
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;
	assign out_best  = best_s2;

endmodule

// File: sv/palette_nearest_color.sv
// channel  dir  handshake            payload
// req      in   valid/ready          op, entry_index, red, green, blue
// rsp      out  valid/ready          closest_index, closest_red/green/blue, distance_squared
// apb      in   psel/penable/pready  paddr, pwdata, prdata (palette_count at 0x0)
//
// One request per cycle while no response is held; after acceptance a query passes through
// the chain of one two-stage cell per palette entry and then the output register.
// Loads travel the chain in order with queries and produce no response.
// Asynchronous reset clears valid bits and sets palette_count to 16; palette undefined.
// A held response stalls the whole chain and drops req.ready.
module palette_nearest_color import pnc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	pnc_req_if.sink           req,
	pnc_rsp_if.source         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic [COUNT_W-1:0] palette_count;
	logic               en;
	logic               ch_valid [PALETTE_DEPTH+1];
	item_t              ch_item  [PALETTE_DEPTH+1];
	best_t              ch_best  [PALETTE_DEPTH+1];
	logic               rsp_valid_q;
	best_t              rsp_best_q;

	pnc_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.palette_count (palette_count)
	);

	assign en = !rsp_valid_q || rsp.ready;
	assign req.ready = en;

	assign ch_valid[0] = req.valid;
	assign ch_item[0].op = op_t'(req.op);
	assign ch_item[0].entry_index = req.entry_index;
	assign ch_item[0].color = '{r: req.red, g: req.green, b: req.blue};
	assign ch_best[0] = '0;

	for (genvar g = 0; g < PALETTE_DEPTH; g++) begin : g_cell
		pnc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.cell_index (IDX_W'(g)),
			.active     ((g == 0) || (32'(g) < 32'(palette_count))),
			.in_valid   (ch_valid[g]),
			.in_item    (ch_item[g]),
			.in_best    (ch_best[g]),
			.out_valid  (ch_valid[g+1]),
			.out_item   (ch_item[g+1]),
			.out_best   (ch_best[g+1])
		);
	end

	// drop loads at the end of the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			rsp_valid_q <= ch_valid[PALETTE_DEPTH] && (ch_item[PALETTE_DEPTH].op == OP_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_best_q <= ch_best[PALETTE_DEPTH];
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.closest_index    = rsp_best_q.index;
	assign rsp.closest_red      = rsp_best_q.color.r;
	assign rsp.closest_green    = rsp_best_q.color.g;
	assign rsp.closest_blue     = rsp_best_q.color.b;
	assign rsp.distance_squared = rsp_best_q.distance;

endmodule

// File: sv/pnc_checker.sv
module pnc_checker import pnc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [3:0]        rsp_closest_index,
	input logic [7:0]        rsp_closest_red,
	input logic [7:0]        rsp_closest_green,
	input logic [7:0]        rsp_closest_blue,
	input logic [DIST_W-1:0] rsp_distance_squared,
	input logic              pready
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_closest_index)
			&& $stable(rsp_closest_red) && $stable(rsp_closest_green)
			&& $stable(rsp_closest_blue) && $stable(rsp_distance_squared))
		else $error("response changed while stalled");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid || rsp_ready |-> req_ready)
		else $error("request stalled with free output");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken while output held");

	a_dist_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_distance_squared <= DIST_MAX)
		else $error("distance out of range");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind palette_nearest_color pnc_checker u_pnc_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.req_ready            (req.ready),
	.rsp_valid            (rsp.valid),
	.rsp_ready            (rsp.ready),
	.rsp_closest_index    (rsp.closest_index),
	.rsp_closest_red      (rsp.closest_red),
	.rsp_closest_green    (rsp.closest_green),
	.rsp_closest_blue     (rsp.closest_blue),
	.rsp_distance_squared (rsp.distance_squared),
	.pready               (pready)
);
